>>> rtl/caob_pkg.sv
// Package with the shared types and constants of the clipped alpha-over blit.
`default_nettype none
package caob_pkg;

	// Panel coordinates at or above this bound never produce a write.
	localparam logic [16:0] PANEL_DIM_MAX = 17'd4096;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 32;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FB_BASE   = 3'd0,
		REG_PITCH     = 3'd1,
		REG_WIDTH     = 3'd2,
		REG_HEIGHT    = 3'd3,
		REG_ORIGIN_X  = 3'd4,
		REG_ORIGIN_Y  = 3'd5,
		REG_DRAW_EN   = 3'd6
	} cfg_reg_t;

	localparam logic [31:0] RST_FB_BASE  = 32'd0;
	localparam logic [18:0] RST_PITCH    = 19'd2560;
	localparam logic [13:0] RST_WIDTH    = 14'd640;
	localparam logic [13:0] RST_HEIGHT   = 14'd480;
	localparam logic [15:0] RST_ORIGIN_X = 16'd0;
	localparam logic [15:0] RST_ORIGIN_Y = 16'd0;
	localparam logic        RST_DRAW_EN  = 1'b1;

	// Register file contents; origins hold two's complement values.
	typedef struct packed {
		logic [31:0] fb_base;
		logic [18:0] row_pitch;
		logic [13:0] disp_width;
		logic [13:0] disp_height;
		logic [15:0] origin_x;
		logic [15:0] origin_y;
		logic        draw_enable;
	} cfg_t;

endpackage
`default_nettype wire

>>> rtl/caob_cfg.sv
// Configuration register file of the clipped alpha-over blit.
`default_nettype none
module caob_cfg (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [caob_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [caob_pkg::CFG_DATA_W-1:0]  cfg_data,
	output caob_pkg::cfg_t                        cfg
);

	caob_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fb_base     <= caob_pkg::RST_FB_BASE;
			cfg_q.row_pitch   <= caob_pkg::RST_PITCH;
			cfg_q.disp_width  <= caob_pkg::RST_WIDTH;
			cfg_q.disp_height <= caob_pkg::RST_HEIGHT;
			cfg_q.origin_x    <= caob_pkg::RST_ORIGIN_X;
			cfg_q.origin_y    <= caob_pkg::RST_ORIGIN_Y;
			cfg_q.draw_enable <= caob_pkg::RST_DRAW_EN;
		end else if (cfg_valid && cfg_ready) begin
			// Indexes beyond the register list fall into the default arm.
			unique case (cfg_index)
				caob_pkg::REG_FB_BASE:  cfg_q.fb_base     <= cfg_data[31:0];
				caob_pkg::REG_PITCH:    cfg_q.row_pitch   <= cfg_data[18:0];
				caob_pkg::REG_WIDTH:    cfg_q.disp_width  <= cfg_data[13:0];
				caob_pkg::REG_HEIGHT:   cfg_q.disp_height <= cfg_data[13:0];
				caob_pkg::REG_ORIGIN_X: cfg_q.origin_x    <= cfg_data[15:0];
				caob_pkg::REG_ORIGIN_Y: cfg_q.origin_y    <= cfg_data[15:0];
				caob_pkg::REG_DRAW_EN:  cfg_q.draw_enable <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

>>> rtl/caob_addr.sv
// Position offset, screen clipping and byte address generation.
`default_nettype none
module caob_addr (
	input  wire caob_pkg::cfg_t cfg,
	input  wire logic [11:0]    panel_row,
	input  wire logic [11:0]    panel_col,
	output logic                write_ok,
	output logic [31:0]         write_address
);

	logic [16:0] sx;
	logic [16:0] sy;
	logic        x_in;
	logic        y_in;
	logic        pitch_ok;
	logic        dim_ok;
	logic [31:0] row_off;

	// 17-bit two's complement sums cover every origin and panel position.
	assign sx = {cfg.origin_x[15], cfg.origin_x} + {5'b0, panel_col};
	assign sy = {cfg.origin_y[15], cfg.origin_y} + {5'b0, panel_row};

	assign x_in = !sx[16] && (sx[15:0] < {2'b0, cfg.disp_width});
	assign y_in = !sy[16] && (sy[15:0] < {2'b0, cfg.disp_height});

	assign pitch_ok = cfg.row_pitch >= {3'b0, cfg.disp_width, 2'b00};
	assign dim_ok   = ({5'b0, panel_row} < caob_pkg::PANEL_DIM_MAX) &&
	                  ({5'b0, panel_col} < caob_pkg::PANEL_DIM_MAX);

	assign write_ok = cfg.draw_enable && pitch_ok && dim_ok && x_in && y_in;

	// On screen the row is below 2^14, so 14 bits feed the multiplier.
	assign row_off = {18'b0, sy[13:0]} * {13'b0, cfg.row_pitch};

	assign write_address = cfg.fb_base + row_off + {16'b0, sx[13:0], 2'b00};

endmodule
`default_nettype wire

>>> rtl/caob_blend.sv
// Straight-alpha source-over-destination blend of one ARGB8888 pixel.
`default_nettype none
module caob_blend (
	input  wire logic [31:0] source_pixel,
	input  wire logic [31:0] dest_pixel,
	output logic [31:0]      blended_pixel
);

	logic [7:0]  alpha;
	logic [23:0] mixed;

	// Rounded (s*a + d*(255-a) + 127) / 255; the sum stays below 2^16, where
	// (p + 1 + (p >> 8)) >> 8 equals the quotient by 255 exactly.
	function automatic logic [7:0] mix_channel(input logic [7:0] s, input logic [7:0] d,
	                                           input logic [7:0] a);
		logic [15:0] p;
		logic [15:0] q;
		p = {8'b0, s} * {8'b0, a} + {8'b0, d} * {8'b0, 8'd255 - a} + 16'd127;
		q = p + 16'd1 + {8'b0, p[15:8]};
		return q[15:8];
	endfunction

	assign alpha = source_pixel[31:24];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mixed[i*8 +: 8] = mix_channel(source_pixel[i*8 +: 8], dest_pixel[i*8 +: 8], alpha);
		end
	end

	always_comb begin
		priority if (alpha == 8'hFF) begin
			blended_pixel = source_pixel;
		end else if (alpha == 8'h00) begin
			blended_pixel = dest_pixel;
		end else begin
			blended_pixel = {8'hFF, mixed};
		end
	end

endmodule
`default_nettype wire

>>> rtl/clipped_alpha_over_blit.sv
// Top level of the clipped alpha-over blit: stream ports, pipeline registers.
`default_nettype none
// The block takes one panel pixel per beat, together with its row and column
// inside the panel and the framebuffer word already at the target spot, and
// returns one result beat per input beat, in order. The position is moved by
// the panel's screen origin and clipped to the screen; a pixel that lands on
// screen while drawing is enabled and the row pitch covers the screen width
// comes back with write flag set, its byte address (base + row*pitch + col*4,
// wrapping at 2^32) and the straight-alpha blend of source over destination.
// Any other pixel comes back with the flag clear and zero data. Throughput is
// one pixel per clock while the consumer keeps tready high: an input register
// feeds the clip, address multiply and three channel blends in parallel, and a
// result register holds the answer. The output stalls back through both
// stages only while the consumer holds tready low. Configuration writes are
// always taken and should only be issued while no pixel is in flight.
module clipped_alpha_over_blit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// Configuration write channel.
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [caob_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [caob_pkg::CFG_DATA_W-1:0]  cfg_data,
	// Pixel input stream.
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	// tdata from bit 0 up: panel_row[11:0], panel_col[11:0],
	// source_pixel[31:0], dest_pixel[31:0].
	input  wire logic [87:0]                      s_axis_tdata,
	// Result stream.
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// tdata from bit 0 up: write_address[31:0], blended_pixel[31:0].
	output logic [63:0]                           m_axis_tdata,
	// tuser: write_valid.
	output logic                                  m_axis_tuser
);

	caob_pkg::cfg_t cfg;

	// Input stage.
	logic        in_valid_s1;
	logic [11:0] in_row_s1;
	logic [11:0] in_col_s1;
	logic [31:0] in_src_s1;
	logic [31:0] in_dst_s1;

	// Result stage.
	logic        out_valid_s2;
	logic        out_write_s2;
	logic [31:0] out_addr_s2;
	logic [31:0] out_pixel_s2;

	logic        advance;
	logic        write_ok;
	logic [31:0] write_address;
	logic [31:0] blended_pixel;

	caob_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The result register can take a new value when it is empty or drained
	// this cycle; the input register refills whenever it moves on.
	assign advance       = !out_valid_s2 || m_axis_tready;
	assign s_axis_tready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			in_row_s1 <= s_axis_tdata[11:0];
			in_col_s1 <= s_axis_tdata[23:12];
			in_src_s1 <= s_axis_tdata[55:24];
			in_dst_s1 <= s_axis_tdata[87:56];
		end
	end

	caob_addr u_addr (
		.cfg           (cfg),
		.panel_row     (in_row_s1),
		.panel_col     (in_col_s1),
		.write_ok      (write_ok),
		.write_address (write_address)
	);

	caob_blend u_blend (
		.source_pixel  (in_src_s1),
		.dest_pixel    (in_dst_s1),
		.blended_pixel (blended_pixel)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= in_valid_s1;
		end
	end

	// A suppressed write carries zero address and zero pixel.
	always_ff @(posedge clk) begin
		if (advance && in_valid_s1) begin
			out_write_s2 <= write_ok;
			out_addr_s2  <= write_ok ? write_address : 32'd0;
			out_pixel_s2 <= write_ok ? blended_pixel : 32'd0;
		end
	end

	assign m_axis_tvalid = out_valid_s2;
	assign m_axis_tuser  = out_write_s2;
	assign m_axis_tdata  = {out_pixel_s2, out_addr_s2};

`ifndef SYNTHESIS
	a_zero_when_suppressed: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 64'd0))
		else $error("suppressed write carries nonzero data");

	a_input_held_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tready && in_valid_s1) |-> (!m_axis_tvalid || m_axis_tready))
		else $error("input stage overwritten while result stage stalls");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> in_valid_s1)
		else $error("accepted beat lost from input stage");

	a_s1_moves_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid_s1 && advance) |=> m_axis_tvalid)
		else $error("input stage item lost on its way to the result stage");
`endif

endmodule
`default_nettype wire
